// File: src/refcounted_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reference-counted page allocator
// Shorthand for clocked properties, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH

// Check cons in the same cycle as ante
`define RPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("page allocator check failed");

// Check cons in the cycle after ante
`define RPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("page allocator check failed");

`endif

// File: src/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared codes, types and defaults of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

	localparam int DEF_NUM_PAGES = 256;
	localparam int DEF_REF_BITS  = 8;

	// request kinds
	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_INCREF = 2'd2;
	localparam logic [1:0] MODE_PEEK   = 2'd3;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_OWNED = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch request, read both memories
		logic exec;     // update memories and result registers
	} cmd_t;

endpackage

// File: src/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// Two-state sequencer: capture a request, then execute it, then strobe.
// ----------------------------------------------------------------------------
module rpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output rpa_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import rpa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	// advance: accept in idle, execute, then return to idle
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.exec;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.exec    = (state_q == S_EXEC);
	assign done        = done_q;

endmodule

// File: src/rpa_datapath.sv
// ----------------------------------------------------------------------------
// rpa_datapath
// Free stack and count memories, stack depth, watermark and result registers.
// ----------------------------------------------------------------------------
module rpa_datapath #(
	parameter int NUM_PAGES = rpa_pkg::DEF_NUM_PAGES,
	parameter int REF_BITS  = rpa_pkg::DEF_REF_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rpa_pkg::cmd_t cmd,
	input  logic [1:0]    mode,
	input  logic [7:0]    page,
	output logic [1:0]    status,
	output logic [7:0]    alloc_page,
	output logic [7:0]    ref_count,
	output logic          returned_to_pool,
	output logic [8:0]    free_count
);
	import rpa_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int DW = $clog2(NUM_PAGES + 1);
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
	localparam logic [DW-1:0]       DEPTH_FULL = DW'(NUM_PAGES);

	// memories
	logic [PW-1:0]       stack_mem [NUM_PAGES];
	logic [REF_BITS-1:0] ref_mem   [NUM_PAGES];

	// depth and low watermark: no stack entry or count below the
	// watermark has been written since reset
	logic [DW-1:0] depth_q;
	logic [DW-1:0] wm_q;

	// captured request and read data
	logic [1:0]          mode_s1;
	logic [7:0]          page_s1;
	logic [PW-1:0]       stk_rd_s1;
	logic [REF_BITS-1:0] ref_rd_s1;

	// result registers
	logic [1:0]    status_q;
	logic [7:0]    alloc_page_q;
	logic [7:0]    ref_count_q;
	logic          back_q;
	logic [8:0]    free_count_q;

	// execute-cycle signals
	logic                in_range;
	logic                ref_written;
	logic [REF_BITS-1:0] cur_ref;
	logic [DW-1:0]       top_pos;
	logic [PW-1:0]       top_page;
	logic [1:0]          stat_nxt;
	logic [PW-1:0]       got_nxt;
	logic [REF_BITS-1:0] cnt_nxt;
	logic                back_nxt;
	logic [DW-1:0]       depth_nxt;
	logic                ref_we;
	logic [PW-1:0]       ref_wa;
	logic [REF_BITS-1:0] ref_wd;
	logic                stk_we;

	// stack memory: push on execute, read top on capture
	always_ff @(posedge clk) begin
		if (cmd.exec && stk_we) stack_mem[PW'(depth_q)] <= PW'(page_s1);
		if (cmd.capture) stk_rd_s1 <= stack_mem[PW'(depth_q - DW'(1))];
	end

	// count memory: write on execute, read addressed page on capture
	always_ff @(posedge clk) begin
		if (cmd.exec && ref_we) ref_mem[ref_wa] <= ref_wd;
		if (cmd.capture) ref_rd_s1 <= ref_mem[PW'(page)];
	end

	// hold request fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_s1 <= mode;
			page_s1 <= page;
		end
	end

	// resolve values of entries that were never written
	assign in_range    = 32'(page_s1) < 32'(NUM_PAGES);
	assign ref_written = 32'(page_s1) >= 32'(wm_q);
	assign cur_ref     = (in_range && ref_written) ? ref_rd_s1 : '0;
	assign top_pos     = depth_q - DW'(1);
	assign top_page    = (top_pos < wm_q) ? PW'(top_pos) : stk_rd_s1;

	// decode the request
	always_comb begin
		stat_nxt  = STAT_OK;
		got_nxt   = '0;
		cnt_nxt   = '0;
		back_nxt  = 1'b0;
		depth_nxt = depth_q;
		ref_we    = 1'b0;
		ref_wa    = PW'(page_s1);
		ref_wd    = '0;
		stk_we    = 1'b0;
		case (mode_s1)
			MODE_ALLOC: begin
				if (depth_q == '0 || depth_q > DEPTH_FULL) begin
					stat_nxt = STAT_EMPTY;
				end else begin
					depth_nxt = top_pos;
					got_nxt   = top_page;
					cnt_nxt   = REF_BITS'(1);
					ref_we    = 1'b1;
					ref_wa    = top_page;
					ref_wd    = REF_BITS'(1);
				end
			end
			MODE_FREE: begin
				if (!in_range || cur_ref == '0) begin
					stat_nxt = STAT_NOT_OWNED;
				end else begin
					cnt_nxt = cur_ref - REF_BITS'(1);
					ref_we  = 1'b1;
					ref_wd  = cnt_nxt;
					if (cnt_nxt == '0 && depth_q < DEPTH_FULL) begin
						stk_we    = 1'b1;
						depth_nxt = depth_q + DW'(1);
						back_nxt  = 1'b1;
					end
				end
			end
			MODE_INCREF: begin
				if (!in_range || cur_ref == '0) begin
					stat_nxt = STAT_NOT_OWNED;
				end else if (cur_ref == REF_MAX) begin
					stat_nxt = STAT_OVERFLOW;
					cnt_nxt  = cur_ref;
				end else begin
					cnt_nxt = cur_ref + REF_BITS'(1);
					ref_we  = 1'b1;
					ref_wd  = cnt_nxt;
				end
			end
			default: begin
				cnt_nxt = cur_ref;
			end
		endcase
	end

	// advance depth and watermark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_FULL;
			wm_q    <= DEPTH_FULL;
		end else if (cmd.exec) begin
			depth_q <= depth_nxt;
			if (depth_nxt < wm_q) wm_q <= depth_nxt;
		end
	end

	// load result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= stat_nxt;
			alloc_page_q <= 8'(got_nxt);
			ref_count_q  <= 8'(cnt_nxt);
			back_q       <= back_nxt;
			free_count_q <= 9'(depth_nxt);
		end
	end

	assign status           = status_q;
	assign alloc_page       = alloc_page_q;
	assign ref_count        = ref_count_q;
	assign returned_to_pool = back_q;
	assign free_count       = free_count_q;

endmodule

// File: src/refcounted_page_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator
// LIFO free-page stack with a reference count per page.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. The
// accepting edge reads the top of the free stack and the addressed page's
// count; in the execute state that follows, the count memory (and the stack
// on a push) is written and the result is loaded. The result is shown with
// done high for exactly one cycle, and busy is already low in that cycle, so
// a new request may be accepted then, but not while busy. The receiver cannot
// stall: it must take each result in its done cycle. No clearing pass runs
// after reset; a watermark on the stack depth marks the entries not yet written.
module refcounted_page_allocator #(
	parameter int NUM_PAGES = rpa_pkg::DEF_NUM_PAGES,
	parameter int REF_BITS  = rpa_pkg::DEF_REF_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] page,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] alloc_page,
	output logic [7:0] ref_count,
	output logic       returned_to_pool,
	output logic [8:0] free_count
);
	import rpa_pkg::*;

	cmd_t cmd;

	rpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rpa_datapath #(
		.NUM_PAGES (NUM_PAGES),
		.REF_BITS  (REF_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.mode             (mode),
		.page             (page),
		.status           (status),
		.alloc_page       (alloc_page),
		.ref_count        (ref_count),
		.returned_to_pool (returned_to_pool),
		.free_count       (free_count)
	);

endmodule

// File: src/rpa_checker.sv
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level timing and result checks, bound to the allocator top level.
// ----------------------------------------------------------------------------
`include "refcounted_page_allocator_macros.svh"

module rpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic [7:0] page,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] alloc_page,
	input logic [7:0] ref_count,
	input logic       returned_to_pool,
	input logic [8:0] free_count
);
	import rpa_pkg::*;

	// an accepted beat keeps the block busy in the execute state, then strobes
	`RPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`RPA_ASSERT_NOW(a_accept_done, start && !busy, ##2 done)
	// a result is shown only while the block is ready again
	`RPA_ASSERT_NOW(a_done_idle, done, !busy)
	// an empty pool hands out nothing
	`RPA_ASSERT_NOW(a_empty_result, done && status == STAT_EMPTY,
		alloc_page == 8'd0 && ref_count == 8'd0 && free_count == 9'd0)
	// a page goes back to the pool only on a clean drop to zero
	`RPA_ASSERT_NOW(a_return_clean, done && returned_to_pool,
		status == STAT_OK && ref_count == 8'd0)

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);
